[sv/crcfp_pkg.sv]
`default_nettype none
package crcfp_pkg;

	localparam int MAX_PAYLOAD_DEF = 32;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [7:0] HEAD_FIRST_RST  = 8'hAA;
	localparam logic [7:0] HEAD_SECOND_RST = 8'h55;
	localparam logic [7:0] TAIL_FIRST_RST  = 8'h0D;
	localparam logic [7:0] TAIL_SECOND_RST = 8'h0A;

	localparam logic [1:0] REG_HEAD_FIRST  = 2'd0;
	localparam logic [1:0] REG_HEAD_SECOND = 2'd1;
	localparam logic [1:0] REG_TAIL_FIRST  = 2'd2;
	localparam logic [1:0] REG_TAIL_SECOND = 2'd3;

	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_GOOD      = 3'd1;
	localparam logic [2:0] EV_BAD_LEN   = 3'd2;
	localparam logic [2:0] EV_BAD_TAIL0 = 3'd3;
	localparam logic [2:0] EV_BAD_TAIL1 = 3'd4;
	localparam logic [2:0] EV_BAD_CRC   = 3'd5;

	// control of the bit-serial CRC unit
	typedef struct packed {
		logic init;   // restart at CRC_INIT
		logic load;   // take a new byte into the shifter
		logic step;   // fold in one bit, MSB first
	} crc_ctrl_t;

endpackage
`default_nettype wire

[sv/crcfp_crc_unit.sv]
`default_nettype none
module crcfp_crc_unit (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire crcfp_pkg::crc_ctrl_t  ctrl,
	input  wire logic [7:0]            byte_in,
	output logic [15:0]                crc
);
	import crcfp_pkg::*;

	logic [15:0] crc_q;
	logic [7:0]  sh_q;
	logic        fb;

	assign fb  = crc_q[15] ^ sh_q[7];
	assign crc = crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctrl.init) begin
			crc_q <= CRC_INIT;
		end else if (ctrl.step) begin
			crc_q <= {crc_q[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sh_q <= byte_in;
		end else if (ctrl.step) begin
			sh_q <= {sh_q[6:0], 1'b0};
		end
	end

endmodule
`default_nettype wire

[sv/crc16_frame_parser.sv]
`default_nettype none
// Channel   Handshake           Payload
// --------  ------------------  ------------------------------------------------
// input     in_valid/in_ready   rx_byte
// output    out_valid/out_ready event_res command frame_length data_byte
//                               data_index data_present last good_count bad_count
// config    APB write/read      paddr pwdata prdata (head/tail sync bytes)
//
// Length, command and payload bytes run through the bit-serial CRC unit, one bit
// per clock: accept, then the SQ_CRC steps, then the result load. Other bytes go
// from accept straight to the result load. A good frame with payload emits one
// payload item per cycle from the payload memory while the output is not stalled.
// Reset is asynchronous, active low; the payload memory is not cleared. in_ready
// is low while a byte is in work; a stalled output holds the sequencer.
module crc16_frame_parser #(
	parameter int MAX_PAYLOAD = crcfp_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    rx_byte,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [2:0]                         event_res,
	output logic [7:0]                         command,
	output logic [5:0]                         frame_length,
	output logic [7:0]                         data_byte,
	output logic [4:0]                         data_index,
	output logic                               data_present,
	output logic                               last,
	output logic [31:0]                        good_count,
	output logic [31:0]                        bad_count,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [crcfp_pkg::PADDR_W-1:0] paddr,
	input  wire logic [crcfp_pkg::PDATA_W-1:0] pwdata,
	output logic [crcfp_pkg::PDATA_W-1:0]      prdata,
	output logic                               pready
);
	import crcfp_pkg::*;

	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	typedef enum logic [8:0] {
		PH_HEAD0   = 9'b000000001,
		PH_HEAD1   = 9'b000000010,
		PH_LEN     = 9'b000000100,
		PH_CMD     = 9'b000001000,
		PH_PAYLOAD = 9'b000010000,
		PH_CRC_LO  = 9'b000100000,
		PH_CRC_HI  = 9'b001000000,
		PH_TAIL0   = 9'b010000000,
		PH_TAIL1   = 9'b100000000
	} phase_t;

	typedef enum logic [3:0] {
		SQ_IDLE   = 4'b0001,
		SQ_CRC    = 4'b0010,
		SQ_RESULT = 4'b0100,
		SQ_EMIT   = 4'b1000
	} seq_t;

	// configuration
	logic [7:0] head_first_q, head_second_q, tail_first_q, tail_second_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_first_q  <= HEAD_FIRST_RST;
			head_second_q <= HEAD_SECOND_RST;
			tail_first_q  <= TAIL_FIRST_RST;
			tail_second_q <= TAIL_SECOND_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_HEAD_FIRST:  head_first_q  <= pwdata[7:0];
				REG_HEAD_SECOND: head_second_q <= pwdata[7:0];
				REG_TAIL_FIRST:  tail_first_q  <= pwdata[7:0];
				REG_TAIL_SECOND: tail_second_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_HEAD_FIRST:  prdata = {24'h0, head_first_q};
			REG_HEAD_SECOND: prdata = {24'h0, head_second_q};
			REG_TAIL_FIRST:  prdata = {24'h0, tail_first_q};
			REG_TAIL_SECOND: prdata = {24'h0, tail_second_q};
			default:         prdata = '0;
		endcase
	end

	// frame state
	phase_t             phase_q, phase_d;
	seq_t               seq_q;
	logic [LEN_W-1:0]   exp_len_q;
	logic [LEN_W-1:0]   fill_q;
	logic [LEN_W-1:0]   fill_next;
	logic [7:0]         cmd_q;
	logic [15:0]        rx_crc_q;
	logic [31:0]        good_q, bad_q;
	logic [2:0]         ev_q, ev_d;
	logic [2:0]         bit_cnt_q;
	logic [IDX_W-1:0]   emit_idx_q;
	logic [LEN_W-1:0]   emit_next;
	logic               emit_last;

	logic               in_xfer, out_free, load_res, load_emit;
	logic               crc_need, crc_init, mem_we, len_we, cmd_we, fill_we;
	logic               crc_lo_we, crc_hi_we, good_inc, bad_inc;
	logic [15:0]        crc_val;
	crc_ctrl_t          crc_ctrl;

	logic [7:0]         payload_mem [MAX_PAYLOAD];
	logic [IDX_W-1:0]   rd_addr;
	logic [7:0]         rd_data_q;

	assign in_ready  = (seq_q == SQ_IDLE);
	assign in_xfer   = in_valid & in_ready;
	assign out_free  = ~out_valid | out_ready;
	assign load_res  = (seq_q == SQ_RESULT) & out_free;
	assign load_emit = (seq_q == SQ_EMIT) & out_free;
	assign fill_next = fill_q + LEN_W'(1);
	assign emit_next = LEN_W'(emit_idx_q) + LEN_W'(1);
	assign emit_last = (emit_next == exp_len_q);

	always_comb begin
		phase_d   = phase_q;
		ev_d      = EV_NONE;
		crc_need  = 1'b0;
		crc_init  = 1'b0;
		mem_we    = 1'b0;
		len_we    = 1'b0;
		cmd_we    = 1'b0;
		fill_we   = 1'b0;
		crc_lo_we = 1'b0;
		crc_hi_we = 1'b0;
		good_inc  = 1'b0;
		bad_inc   = 1'b0;
		unique case (phase_q)
			PH_HEAD0: begin
				if (rx_byte == head_first_q) phase_d = PH_HEAD1;
			end
			PH_HEAD1: begin
				// head_second wins over a repeated head_first
				if (rx_byte == head_second_q) begin
					phase_d  = PH_LEN;
					crc_init = 1'b1;
				end else if (rx_byte != head_first_q) begin
					phase_d = PH_HEAD0;
				end
			end
			PH_LEN: begin
				if (rx_byte > 8'(MAX_PAYLOAD)) begin
					phase_d = PH_HEAD0;
					ev_d    = EV_BAD_LEN;
					bad_inc = 1'b1;
				end else begin
					phase_d  = PH_CMD;
					len_we   = 1'b1;
					crc_need = 1'b1;
				end
			end
			PH_CMD: begin
				cmd_we   = 1'b1;
				crc_need = 1'b1;
				phase_d  = (exp_len_q == '0) ? PH_CRC_LO : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				mem_we   = 1'b1;
				fill_we  = 1'b1;
				crc_need = 1'b1;
				if (fill_next >= exp_len_q) phase_d = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				crc_lo_we = 1'b1;
				phase_d   = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				crc_hi_we = 1'b1;
				phase_d   = PH_TAIL0;
			end
			PH_TAIL0: begin
				if (rx_byte == tail_first_q) begin
					phase_d = PH_TAIL1;
				end else begin
					phase_d = PH_HEAD0;
					ev_d    = EV_BAD_TAIL0;
					bad_inc = 1'b1;
				end
			end
			PH_TAIL1: begin
				phase_d = PH_HEAD0;
				if (rx_byte != tail_second_q) begin
					ev_d    = EV_BAD_TAIL1;
					bad_inc = 1'b1;
				end else if (crc_val != rx_crc_q) begin
					ev_d    = EV_BAD_CRC;
					bad_inc = 1'b1;
				end else begin
					ev_d     = EV_GOOD;
					good_inc = 1'b1;
				end
			end
			default: phase_d = PH_HEAD0;
		endcase
	end

	assign crc_ctrl.init = in_xfer & crc_init;
	assign crc_ctrl.load = in_xfer & crc_need;
	assign crc_ctrl.step = (seq_q == SQ_CRC);

	crcfp_crc_unit u_crc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (crc_ctrl),
		.byte_in (rx_byte),
		.crc     (crc_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEAD0;
			seq_q      <= SQ_IDLE;
			exp_len_q  <= '0;
			fill_q     <= '0;
			cmd_q      <= '0;
			rx_crc_q   <= '0;
			good_q     <= '0;
			bad_q      <= '0;
			ev_q       <= EV_NONE;
			bit_cnt_q  <= '0;
			emit_idx_q <= '0;
		end else begin
			if (in_xfer) begin
				phase_q <= phase_d;
				ev_q    <= ev_d;
				if (len_we) begin
					exp_len_q <= LEN_W'(rx_byte);
					fill_q    <= '0;
				end
				if (fill_we)   fill_q         <= fill_next;
				if (cmd_we)    cmd_q          <= rx_byte;
				if (crc_lo_we) rx_crc_q       <= {8'h00, rx_byte};
				if (crc_hi_we) rx_crc_q[15:8] <= rx_byte;
				if (good_inc)  good_q         <= good_q + 32'd1;
				if (bad_inc)   bad_q          <= bad_q + 32'd1;
			end
			unique case (seq_q)
				SQ_IDLE: begin
					if (in_xfer) begin
						bit_cnt_q  <= '0;
						emit_idx_q <= '0;
						if (crc_need) begin
							seq_q <= SQ_CRC;
						end else if (ev_d == EV_GOOD && exp_len_q != '0) begin
							seq_q <= SQ_EMIT;
						end else begin
							seq_q <= SQ_RESULT;
						end
					end
				end
				SQ_CRC: begin
					bit_cnt_q <= bit_cnt_q + 3'd1;
					if (bit_cnt_q == 3'd7) seq_q <= SQ_RESULT;
				end
				SQ_RESULT: begin
					if (out_free) seq_q <= SQ_IDLE;
				end
				SQ_EMIT: begin
					if (out_free) begin
						emit_idx_q <= IDX_W'(emit_next);
						if (emit_last) seq_q <= SQ_IDLE;
					end
				end
				default: seq_q <= SQ_IDLE;
			endcase
		end
	end

	// read one entry ahead so the next item is ready when the output frees up
	always_comb begin
		if (load_emit) begin
			rd_addr = IDX_W'(emit_next);
		end else if (seq_q == SQ_EMIT) begin
			rd_addr = emit_idx_q;
		end else begin
			rd_addr = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && mem_we) payload_mem[IDX_W'(fill_q)] <= rx_byte;
		rd_data_q <= payload_mem[rd_addr];
	end

	// output register
	logic        out_valid_q;
	logic [2:0]  event_res_q;
	logic [7:0]  command_q;
	logic [5:0]  frame_length_q;
	logic [7:0]  data_byte_q;
	logic [4:0]  data_index_q;
	logic        data_present_q;
	logic        last_q;
	logic [31:0] good_count_q, bad_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res || load_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			event_res_q    <= ev_q;
			command_q      <= (ev_q == EV_GOOD) ? cmd_q : 8'h00;
			frame_length_q <= '0;
			data_byte_q    <= '0;
			data_index_q   <= '0;
			data_present_q <= 1'b0;
			last_q         <= 1'b1;
			good_count_q   <= good_q;
			bad_count_q    <= bad_q;
		end else if (load_emit) begin
			event_res_q    <= EV_GOOD;
			command_q      <= cmd_q;
			frame_length_q <= 6'(exp_len_q);
			data_byte_q    <= rd_data_q;
			data_index_q   <= 5'(emit_idx_q);
			data_present_q <= 1'b1;
			last_q         <= emit_last;
			good_count_q   <= good_q;
			bad_count_q    <= bad_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = event_res_q;
	assign command      = command_q;
	assign frame_length = frame_length_q;
	assign data_byte    = data_byte_q;
	assign data_index   = data_index_q;
	assign data_present = data_present_q;
	assign last         = last_q;
	assign good_count   = good_count_q;
	assign bad_count    = bad_count_q;

endmodule
`default_nettype wire
